[hw/rtl/overwriting_byte_log_ring_macros.svh]
`ifndef OVERWRITING_BYTE_LOG_RING_MACROS_SVH
`define OVERWRITING_BYTE_LOG_RING_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define OBL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overwriting_byte_log_ring: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define OBL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overwriting_byte_log_ring: assertion failed");

`endif

[hw/rtl/obl_pkg.sv]
`default_nettype none

package obl_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int HELD_W     = PTR_W + 1;
    localparam int MAX_WINDOW = 64;
    localparam int COUNT_W    = 7;
    localparam int DATA_W     = 8;
    localparam int OFFSET_W   = 14;
    localparam int CQ_DEPTH   = 4;
    localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_EMPTY  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef struct packed {
        logic                kind;
        logic [DATA_W-1:0]   append_byte;
        logic [OFFSET_W-1:0] start_offset;
        logic [COUNT_W-1:0]  max_bytes;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data_byte;
        logic               last;
        logic               empty_res;
        logic [COUNT_W-1:0] returned_count;
        logic [HELD_W-1:0]  held_bytes;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic [PTR_W-1:0]   addr;
        logic [DATA_W-1:0]  wdata;
        logic [COUNT_W-1:0] count;
        logic [HELD_W-1:0]  held;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/obl_front.sv]
`default_nettype none

module obl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  obl_pkg::in_item_t request,
    input  logic              q_full,
    output logic              q_push,
    output obl_pkg::cmd_t     q_cmd
);
    import obl_pkg::*;

    logic [PTR_W-1:0]   wpos_reg;
    logic [PTR_W-1:0]   wpos_next;
    logic               full_flag_reg;
    logic               full_flag_next;
    logic               accept;
    logic               wrap;
    logic               full_after;
    logic [PTR_W-1:0]   wpos_inc;
    logic [PTR_W-1:0]   start;
    logic [HELD_W-1:0]  held;
    logic [HELD_W-1:0]  held_after;
    logic [HELD_W-1:0]  offset;
    logic [HELD_W-1:0]  avail;
    logic [COUNT_W-1:0] cap;

    always_comb
    begin
        accept     = push && !q_full;
        q_push     = accept;
        held       = full_flag_reg ? HELD_W'(RING_DEPTH) : {1'b0, wpos_reg};
        wpos_inc   = wpos_reg + PTR_W'(1);
        wrap       = (wpos_reg == PTR_W'(RING_DEPTH - 1));
        full_after = full_flag_reg || wrap;
        held_after = full_after ? HELD_W'(RING_DEPTH) : {1'b0, wpos_inc};
        offset     = HELD_W'(request.start_offset);
        avail      = held - offset;
        start      = full_flag_reg ? wpos_reg : '0;
        cap        = (request.max_bytes > COUNT_W'(MAX_WINDOW)) ?
                     COUNT_W'(MAX_WINDOW) : request.max_bytes;

        wpos_next      = wpos_reg;
        full_flag_next = full_flag_reg;

        q_cmd.op    = OP_EMPTY;
        q_cmd.addr  = wpos_reg;
        q_cmd.wdata = request.append_byte;
        q_cmd.count = '0;
        q_cmd.held  = held;

        if (request.kind == KIND_APPEND)
        begin
            q_cmd.op   = OP_APPEND;
            q_cmd.held = held_after;
            if (accept)
            begin
                wpos_next      = wpos_inc;
                full_flag_next = full_after;
            end
        end
        else if (cap != '0 && offset < held)
        begin
            q_cmd.op    = OP_READ;
            q_cmd.addr  = start + offset[PTR_W-1:0];
            q_cmd.count = (avail > HELD_W'(cap)) ? cap : avail[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg      <= '0;
            full_flag_reg <= 1'b0;
        end
        else
        begin
            wpos_reg      <= wpos_next;
            full_flag_reg <= full_flag_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/obl_cmd_queue.sv]
`default_nettype none

module obl_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  obl_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd_en,
    output logic          valid,
    output obl_pkg::cmd_t rd_cmd
);
    import obl_pkg::*;

    cmd_t                slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W:0]   cnt_reg;
    logic [CQ_PTR_W:0]   cnt_next;
    logic                do_wr;
    logic                do_rd;

    always_comb
    begin
        full     = (cnt_reg == (CQ_PTR_W+1)'(CQ_DEPTH));
        valid    = (cnt_reg != '0);
        rd_cmd   = slot_reg[rd_ptr_reg];
        do_wr    = wr_en && !full;
        do_rd    = rd_en && valid;
        cnt_next = cnt_reg + (CQ_PTR_W+1)'(do_wr) - (CQ_PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CQ_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CQ_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/obl_back.sv]
`default_nettype none

`include "overwriting_byte_log_ring_macros.svh"

module obl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  obl_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output obl_pkg::out_item_t result
);
    import obl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_STREAM = 2'b10
    } back_state_t;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [PTR_W-1:0]     addr_reg;
    logic [PTR_W-1:0]     addr_next;
    logic [COUNT_W-1:0]   remain_reg;
    logic [COUNT_W-1:0]   remain_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [HELD_W-1:0]    held_reg;
    logic [HELD_W-1:0]    held_next;

    logic [DATA_W-1:0]    ring_mem [RING_DEPTH];
    logic [DATA_W-1:0]    mem_q_reg;
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_addr;

    logic                 issue;
    logic                 room;
    out_item_t            s1_next;
    logic                 s1_mem_next;
    logic                 v1_reg;
    out_item_t            s1_reg;
    logic                 s1_mem_reg;

    out_item_t            out_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_ptr_reg;
    logic [OUT_PTR_W-1:0] out_rd_ptr_reg;
    logic [OUT_PTR_W:0]   out_cnt_reg;
    logic                 out_pop;
    out_item_t            out_push_item;

    always_comb
    begin
        room = (out_cnt_reg + (OUT_PTR_W+1)'(v1_reg)) < (OUT_PTR_W+1)'(OUT_DEPTH);

        issue       = 1'b0;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = addr_reg;
        state_next  = state_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        held_next   = held_reg;

        s1_mem_next            = 1'b0;
        s1_next.data_byte      = '0;
        s1_next.last           = 1'b1;
        s1_next.empty_res      = 1'b1;
        s1_next.returned_count = '0;
        s1_next.held_bytes     = cmd.held;

        unique case (state_reg)
            ST_STREAM:
            begin
                if (room)
                begin
                    issue                  = 1'b1;
                    s1_mem_next            = 1'b1;
                    s1_next.last           = (remain_reg == COUNT_W'(1));
                    s1_next.empty_res      = 1'b0;
                    s1_next.returned_count = count_reg;
                    s1_next.held_bytes     = held_reg;
                    addr_next              = addr_reg + PTR_W'(1);
                    remain_next            = remain_reg - COUNT_W'(1);
                    if (remain_reg == COUNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (room && cmd_valid)
                begin
                    issue    = 1'b1;
                    cmd_pop  = 1'b1;
                    mem_addr = cmd.addr;
                    unique case (cmd.op)
                        OP_APPEND:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_READ:
                        begin
                            s1_mem_next            = 1'b1;
                            s1_next.last           = (cmd.count == COUNT_W'(1));
                            s1_next.empty_res      = 1'b0;
                            s1_next.returned_count = cmd.count;
                            if (cmd.count != COUNT_W'(1))
                            begin
                                state_next  = ST_STREAM;
                                addr_next   = cmd.addr + PTR_W'(1);
                                remain_next = cmd.count - COUNT_W'(1);
                                count_next  = cmd.count;
                                held_next   = cmd.held;
                            end
                        end
                        default:
                        begin
                            s1_mem_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_push_item           = s1_reg;
        out_push_item.data_byte = s1_mem_reg ? mem_q_reg : '0;

        empty   = (out_cnt_reg == '0);
        out_pop = pop && !empty;
        result  = out_reg[out_rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            if (mem_we)
            begin
                ring_mem[mem_addr] <= cmd.wdata;
            end
            else
            begin
                mem_q_reg <= ring_mem[mem_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg     <= s1_next;
            s1_mem_reg <= s1_mem_next;
        end
        if (v1_reg)
        begin
            out_reg[out_wr_ptr_reg] <= out_push_item;
        end
        addr_reg   <= addr_next;
        remain_reg <= remain_next;
        count_reg  <= count_next;
        held_reg   <= held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            v1_reg         <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            if (v1_reg)
            begin
                out_wr_ptr_reg <= out_wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + OUT_PTR_W'(1);
            end
            out_cnt_reg <= out_cnt_reg + (OUT_PTR_W+1)'(v1_reg)
                           - (OUT_PTR_W+1)'(out_pop);
        end
    end

    `OBL_ASSERT_IMP(a_out_no_overflow, v1_reg, (out_cnt_reg < (OUT_PTR_W+1)'(OUT_DEPTH)) || out_pop)
    `OBL_ASSERT_IMP(a_pop_needs_cmd, cmd_pop, cmd_valid && state_reg == ST_IDLE)
    `OBL_ASSERT_IMP(a_stream_has_bytes, state_reg == ST_STREAM, remain_reg != '0)
    `OBL_ASSERT_NEXT(a_last_ends_stream, issue && s1_next.last && state_reg == ST_STREAM, state_reg == ST_IDLE)

endmodule

`default_nettype wire

[hw/rtl/overwriting_byte_log_ring.sv]
// Append: one item per cycle unless a full queue stalls it; its result passes the command
// queue, the back-end stage register and the result queue. Read: one byte per cycle from the
// single-port ring memory while the result queue has room; the window blocks later commands.
// A four-entry command queue and a four-entry result queue decouple input and output.
// Reset clears write position, wrap flag and both queues; ring memory is not cleared.
`default_nettype none

module overwriting_byte_log_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  obl_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output obl_pkg::out_item_t result
);
    import obl_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_in_cmd;
    cmd_t q_out_cmd;

    obl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .q_full  (full),
        .q_push  (q_push),
        .q_cmd   (q_in_cmd)
    );

    obl_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (q_in_cmd),
        .full   (full),
        .rd_en  (q_pop),
        .valid  (q_valid),
        .rd_cmd (q_out_cmd)
    );

    obl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_out_cmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
